// ----- sv/deque_with_erase_by_value_assert.svh -----
// assertion macros used by the checker file
`ifndef DEQUE_WITH_ERASE_BY_VALUE_ASSERT_SVH
`define DEQUE_WITH_ERASE_BY_VALUE_ASSERT_SVH

// checked only while out of reset
`define DQE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define DQE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/dqe_pkg.sv -----
`timescale 1ns / 1ps
package dqe_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_ERASE      = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_ERASE = 1'b1
  } state_e;

  typedef enum logic [2:0] {
    CELL_HOLD        = 3'd0,
    CELL_LOAD_AT     = 3'd1,
    CELL_SHIFT_BACK  = 3'd2,
    CELL_SHIFT_FRONT = 3'd3,
    CELL_ERASE_STEP  = 3'd4
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     carry;
  } cell_ctrl_t;

endpackage

// ----- sv/dqe_cell.sv -----
`timescale 1ns / 1ps
module dqe_cell import dqe_pkg::*; #(
  parameter int VALUE_WIDTH = 32,
  parameter int IDX_W       = 5,
  parameter int INDEX       = 0
) (
  input  logic                   clk_i,
  input  cell_ctrl_t             ctrl_i,
  input  logic [IDX_W-1:0]       idx_i,
  input  logic [VALUE_WIDTH-1:0] din_i,
  input  logic [VALUE_WIDTH-1:0] left_i,
  input  logic [VALUE_WIDTH-1:0] right_i,
  output logic [VALUE_WIDTH-1:0] value_o,
  output logic [VALUE_WIDTH-1:0] tap_o,
  output logic                   hit_o
);

  logic [VALUE_WIDTH-1:0] value_q;
  logic [VALUE_WIDTH-1:0] value_d;
  logic                   sel;
  logic                   eq;

  assign sel   = (idx_i == IDX_W'(INDEX));
  assign eq    = (value_q == din_i);
  assign hit_o = sel && eq;
  assign tap_o = sel ? value_q : '0;
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    case (ctrl_i.op)
      CELL_LOAD_AT: begin
        if (sel) value_d = din_i;
      end
      CELL_SHIFT_BACK: begin
        value_d = left_i;
      end
      CELL_SHIFT_FRONT: begin
        value_d = right_i;
      end
      CELL_ERASE_STEP: begin
        // once the match is at or before this cell, close the gap
        if (sel && (ctrl_i.carry || eq)) value_d = right_i;
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ----- sv/deque_with_erase_by_value.sv -----
// Bounded double-ended queue of DEPTH values with erase of the first match.
// Input channel (in_valid_i / in_ready_o) carries operation_i and item_value_i;
// output channel (out_valid_o / out_ready_i) returns status_o, removed_value_o
// and occupancy_o, one result transaction per input transaction, in order.
// Storage is a row of DEPTH cells; a front add or remove moves every cell
// one place at once and a back add or remove uses one cell in place, so the
// result is registered at the accepting edge, shows in the next cycle, and
// a new transaction can be taken every cycle outside erase and output stalls.
// Erase walks a single step pointer down the occupied cells, one cell per
// cycle, compacting behind the match as it goes; the input stays not ready
// until the walk ends and its result is loaded.
// Reset clears the occupancy, the sequencer and the output valid; the cell
// contents are not cleared and are never read before being written.
// A result waiting on a stalled receiver sits in the output register; the
// input stays ready only if that register drains in the same cycle.
`timescale 1ns / 1ps
module deque_with_erase_by_value import dqe_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [31:0] item_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] removed_value_o,
  output logic [4:0]  occupancy_o
);

  localparam int IDX_W = $clog2(DEPTH + 1);

  state_e                 state_q, state_d;
  logic [IDX_W-1:0]       cnt_q, cnt_d;
  logic [IDX_W-1:0]       k_q, k_d;
  logic                   carry_q, carry_d;
  logic [VALUE_WIDTH-1:0] key_q, key_d;

  logic                   out_valid_q;
  status_e                out_status_q, status_d;
  logic [VALUE_WIDTH-1:0] out_removed_q, removed_d;
  logic [IDX_W-1:0]       out_occ_q;
  logic                   load_out;

  cell_ctrl_t             cell_ctrl;
  logic [IDX_W-1:0]       cell_idx;
  logic [VALUE_WIDTH-1:0] cell_din;
  logic [VALUE_WIDTH-1:0] in_value;

  logic [VALUE_WIDTH-1:0] value [DEPTH];
  logic [VALUE_WIDTH-1:0] tap   [DEPTH];
  logic [VALUE_WIDTH-1:0] left  [DEPTH];
  logic [VALUE_WIDTH-1:0] right [DEPTH];
  logic [DEPTH-1:0]       hit;
  logic [VALUE_WIDTH-1:0] tap_or;
  logic                   accept;
  logic                   full;
  logic                   empty;

  assign in_value   = VALUE_WIDTH'(item_value_i);
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (cnt_q == IDX_W'(DEPTH));
  assign empty      = (cnt_q == '0);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_left_end
      assign left[i] = cell_din;
    end else begin : g_left
      assign left[i] = value[i-1];
    end
    if (i == DEPTH - 1) begin : g_right_end
      assign right[i] = '0;
    end else begin : g_right
      assign right[i] = value[i+1];
    end

    dqe_cell #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .IDX_W      (IDX_W),
      .INDEX      (i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl),
      .idx_i  (cell_idx),
      .din_i  (cell_din),
      .left_i (left[i]),
      .right_i(right[i]),
      .value_o(value[i]),
      .tap_o  (tap[i]),
      .hit_o  (hit[i])
    );
  end

  // only the addressed cell drives a nonzero tap
  always_comb begin
    tap_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tap_or = tap_or | tap[i];
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    carry_d   = carry_q;
    key_d     = key_q;
    cell_ctrl = '{op: CELL_HOLD, carry: 1'b0};
    cell_idx  = cnt_q;
    cell_din  = in_value;
    load_out  = 1'b0;
    status_d  = STATUS_OK;
    removed_d = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (operation_i)
            OP_PUSH_BACK: begin
              load_out = 1'b1;
              if (full) begin
                status_d = STATUS_FULL;
              end else begin
                cell_ctrl.op = CELL_LOAD_AT;
                cnt_d        = cnt_q + IDX_W'(1);
              end
            end
            OP_POP_BACK: begin
              load_out = 1'b1;
              cell_idx = cnt_q - IDX_W'(1);
              if (empty) begin
                status_d = STATUS_EMPTY;
              end else begin
                removed_d = tap_or;
                cnt_d     = cnt_q - IDX_W'(1);
              end
            end
            OP_PUSH_FRONT: begin
              load_out = 1'b1;
              if (full) begin
                status_d = STATUS_FULL;
              end else begin
                cell_ctrl.op = CELL_SHIFT_BACK;
                cnt_d        = cnt_q + IDX_W'(1);
              end
            end
            OP_POP_FRONT: begin
              load_out = 1'b1;
              if (empty) begin
                status_d = STATUS_EMPTY;
              end else begin
                removed_d    = value[0];
                cell_ctrl.op = CELL_SHIFT_FRONT;
                cnt_d        = cnt_q - IDX_W'(1);
              end
            end
            OP_ERASE: begin
              key_d   = in_value;
              k_d     = '0;
              carry_d = 1'b0;
              state_d = ST_ERASE;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_ERASE: begin
        cell_din = key_q;
        cell_idx = k_q;
        if (k_q < cnt_q) begin
          cell_ctrl = '{op: CELL_ERASE_STEP, carry: carry_q};
          carry_d   = carry_q | (|hit);
          k_d       = k_q + IDX_W'(1);
        end else begin
          load_out = 1'b1;
          status_d = carry_q ? STATUS_OK : STATUS_NOT_FOUND;
          cnt_d    = cnt_q - IDX_W'(carry_q);
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      carry_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      carry_q <= carry_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (load_out) begin
      out_status_q  <= status_d;
      out_removed_q <= removed_d;
      out_occ_q     <= cnt_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign removed_value_o = 32'(out_removed_q);
  assign occupancy_o     = 5'(out_occ_q);

endmodule

// ----- sv/dqe_checker.sv -----
`timescale 1ns / 1ps
`include "deque_with_erase_by_value_assert.svh"
module dqe_checker import dqe_pkg::*; #(
  parameter int DEPTH = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [31:0] removed_value_o,
  input logic [4:0]  occupancy_o
);

  // a stalled result transaction keeps its payload
  `DQE_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(removed_value_o) && $stable(occupancy_o), "stalled result changed")

  // reset clears the valid asynchronously; the check is made at the following edge
  `DQE_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid_o, "result valid in reset")

  // no new transaction while the pending result is held back
  `DQE_ASSERT(a_no_overrun, clk_i, rst_ni, out_valid_o && !out_ready_i |-> !in_ready_o, "input ready over a stalled result")

  `DQE_ASSERT(a_status_occ, clk_i, rst_ni, out_valid_o && (status_o == STATUS_FULL) |-> occupancy_o == 5'(DEPTH), "full status without full occupancy")

  `DQE_ASSERT(a_removed_ok, clk_i, rst_ni, out_valid_o && (removed_value_o != 32'd0) |-> status_o == STATUS_OK, "removed value with failure status")

endmodule

bind deque_with_erase_by_value dqe_checker #(.DEPTH(DEPTH)) u_dqe_checker (.*);
